### hw/rtl/ffsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffsc_pkg
// Shared types and constants of the front-end frame sequence checker.
// ----------------------------------------------------------------------------
package ffsc_pkg;

    localparam int FRAME_COUNT_DEFAULT = 4;
    localparam int FRAME_INDEX_W       = 4;
    localparam int ADDR_W              = 3;
    localparam int DATA_W              = 32;

    typedef struct packed {
        logic       enable;
        logic [3:0] uncompressed_mode_code;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        trigger_value;
        logic [3:0]        run_mode;
        logic signed [15:0] last_payload_length;
    } result_t;

endpackage
`default_nettype wire

### hw/rtl/ffsc_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffsc_cfg
// APB configuration registers: enable and uncompressed mode code.
// ----------------------------------------------------------------------------
module ffsc_cfg
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ffsc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ffsc_pkg::DATA_W-1:0]   pwdata,
    output logic      [ffsc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output ffsc_pkg::cfg_t                     cfg
);

    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_UMC    = 1'b1;

    logic       enable_reg;
    logic [3:0] umc_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            umc_reg    <= 4'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_ENABLE: enable_reg <= pwdata[0];
                REG_UMC:    umc_reg    <= pwdata[3:0];
                default:    enable_reg <= enable_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_ENABLE: prdata[0]   = enable_reg;
            REG_UMC:    prdata[3:0] = umc_reg;
            default:    prdata      = '0;
        endcase
    end

    assign cfg.enable                 = enable_reg;
    assign cfg.uncompressed_mode_code = umc_reg;

endmodule
`default_nettype wire

### hw/rtl/ffsc_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffsc_parser
// Frame parser state machine: checks sync, trigger and mode of each frame,
// walks length, payload groups and trailer, and flags a result.
// ----------------------------------------------------------------------------
module ffsc_parser
#(
    parameter int FRAME_COUNT = ffsc_pkg::FRAME_COUNT_DEFAULT
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      data_byte,
    input  wire ffsc_pkg::cfg_t  cfg,
    output logic                 emit,
    output ffsc_pkg::result_t    result
);

    typedef enum logic [7:0] {
        PH_SYNC1 = 8'b0000_0001,
        PH_SYNC2 = 8'b0000_0010,
        PH_TRIG  = 8'b0000_0100,
        PH_MODE  = 8'b0000_1000,
        PH_LENH  = 8'b0001_0000,
        PH_LENL  = 8'b0010_0000,
        PH_PAY   = 8'b0100_0000,
        PH_TRAIL = 8'b1000_0000
    } phase_t;

    localparam logic [7:0]  SYNC_A     = 8'hEB;
    localparam logic [7:0]  SYNC_B     = 8'h90;
    localparam logic [15:0] LEN_OFFSET = 16'd6;
    localparam logic [1:0]  GROUP_UNC  = 2'd2;
    localparam logic [1:0]  GROUP_CMP  = 2'd3;
    localparam logic [1:0]  TRAIL_LAST = 2'd3;
    localparam logic [2:0]  ST_OK      = 3'd0;
    localparam logic [2:0]  ST_SYNC1   = 3'd1;
    localparam logic [2:0]  ST_SYNC2   = 3'd2;
    localparam logic [2:0]  ST_TRIG    = 3'd3;
    localparam logic [2:0]  ST_MODE    = 3'd4;
    localparam int          FI_W       = ffsc_pkg::FRAME_INDEX_W;
    localparam logic [FI_W:0] FRAME_LIMIT = (FI_W+1)'(FRAME_COUNT);

    phase_t            phase_reg,   phase_next;
    logic [FI_W-1:0]   frame_reg,   frame_next;
    logic [7:0]        trig_reg,    trig_next;
    logic [3:0]        mode_reg,    mode_next;
    logic [7:0]        lenh_reg,    lenh_next;
    logic [15:0]       remain_reg,  remain_next;
    logic [1:0]        group_reg,   group_next;
    logic [1:0]        trail_reg,   trail_next;
    logic [15:0]       len_reg,     len_next;

    logic [2:0]        status;
    logic [15:0]       len_calc;
    logic [1:0]        group_size;
    logic [1:0]        group_inc;
    logic [15:0]       remain_sub;
    logic [FI_W:0]     frame_inc;

    assign len_calc   = {lenh_reg, data_byte} - LEN_OFFSET;
    assign group_size = (mode_reg == cfg.uncompressed_mode_code) ? GROUP_UNC : GROUP_CMP;
    assign group_inc  = group_reg + 2'd1;
    assign remain_sub = (remain_reg > {14'd0, group_size}) ?
                        remain_reg - {14'd0, group_size} : 16'd0;
    assign frame_inc  = {1'b0, frame_reg} + {{FI_W{1'b0}}, 1'b1};

    always_comb
    begin
        phase_next  = phase_reg;
        frame_next  = frame_reg;
        trig_next   = trig_reg;
        mode_next   = mode_reg;
        lenh_next   = lenh_reg;
        remain_next = remain_reg;
        group_next  = group_reg;
        trail_next  = trail_reg;
        len_next    = len_reg;
        emit        = 1'b0;
        status      = ST_OK;

        if (step)
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    if (data_byte != SYNC_A)
                    begin
                        emit   = 1'b1;
                        status = ST_SYNC1;
                    end
                    else
                        phase_next = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    if (data_byte != SYNC_B)
                    begin
                        emit   = 1'b1;
                        status = ST_SYNC2;
                    end
                    else
                        phase_next = PH_TRIG;
                end
                PH_TRIG:
                begin
                    if (frame_reg == '0)
                    begin
                        trig_next  = data_byte;
                        phase_next = PH_MODE;
                    end
                    else if (trig_reg != data_byte)
                    begin
                        emit   = 1'b1;
                        status = ST_TRIG;
                    end
                    else
                        phase_next = PH_MODE;
                end
                PH_MODE:
                begin
                    if (frame_reg == '0)
                    begin
                        mode_next  = data_byte[7:4];
                        phase_next = PH_LENH;
                    end
                    else if (mode_reg != data_byte[7:4])
                    begin
                        emit   = 1'b1;
                        status = ST_MODE;
                    end
                    else
                        phase_next = PH_LENH;
                end
                PH_LENH:
                begin
                    lenh_next  = data_byte;
                    phase_next = PH_LENL;
                end
                PH_LENL:
                begin
                    len_next   = len_calc;
                    group_next = 2'd0;
                    trail_next = 2'd0;
                    if ((len_calc == 16'd0) || len_calc[15])
                    begin
                        remain_next = 16'd0;
                        phase_next  = PH_TRAIL;
                    end
                    else
                    begin
                        remain_next = len_calc;
                        phase_next  = PH_PAY;
                    end
                end
                PH_PAY:
                begin
                    if (group_inc >= group_size)
                    begin
                        group_next  = 2'd0;
                        remain_next = remain_sub;
                        if (remain_sub == 16'd0)
                        begin
                            trail_next = 2'd0;
                            phase_next = PH_TRAIL;
                        end
                    end
                    else
                        group_next = group_inc;
                end
                PH_TRAIL:
                begin
                    if (trail_reg < TRAIL_LAST)
                        trail_next = trail_reg + 2'd1;
                    else
                    begin
                        trail_next = 2'd0;
                        if (frame_inc >= FRAME_LIMIT)
                        begin
                            emit   = 1'b1;
                            status = ST_OK;
                        end
                        else
                        begin
                            frame_next = frame_inc[FI_W-1:0];
                            phase_next = PH_SYNC1;
                        end
                    end
                end
                default:
                    phase_next = PH_SYNC1;
            endcase

            if (emit)
            begin
                phase_next  = PH_SYNC1;
                frame_next  = '0;
                group_next  = 2'd0;
                trail_next  = 2'd0;
                remain_next = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SYNC1;
            frame_reg  <= '0;
            trig_reg   <= 8'd0;
            mode_reg   <= 4'd0;
            lenh_reg   <= 8'd0;
            remain_reg <= 16'd0;
            group_reg  <= 2'd0;
            trail_reg  <= 2'd0;
            len_reg    <= 16'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            frame_reg  <= frame_next;
            trig_reg   <= trig_next;
            mode_reg   <= mode_next;
            lenh_reg   <= lenh_next;
            remain_reg <= remain_next;
            group_reg  <= group_next;
            trail_reg  <= trail_next;
            len_reg    <= len_next;
        end
    end

    assign result.status              = status;
    assign result.trigger_value       = trig_reg;
    assign result.run_mode            = mode_reg;
    assign result.last_payload_length = len_reg;

endmodule
`default_nettype wire

### hw/rtl/fee_frame_sequence_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fee_frame_sequence_checker
// Checks the frame sequence of one event in a front-end byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while the input is not stalled. Each byte
// passes an input register, then the parser updates its state and, on the
// first error or after the trailer of the last frame, loads one item into
// the result register. The input stalls only while a result waits to be
// taken and the input register holds a byte.
// With enable low, bytes are taken and dropped. Write configuration only while
// the block is idle.
// ----------------------------------------------------------------------------
module fee_frame_sequence_checker
#(
    parameter int FRAME_COUNT = ffsc_pkg::FRAME_COUNT_DEFAULT
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ffsc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ffsc_pkg::DATA_W-1:0]   pwdata,
    output logic      [ffsc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [2:0]                         status,
    output logic [7:0]                         trigger_value,
    output logic [3:0]                         run_mode,
    output logic signed [15:0]                 last_payload_length
);

    ffsc_pkg::cfg_t    cfg;
    ffsc_pkg::result_t result;
    ffsc_pkg::result_t res_reg;

    logic       byte_valid_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    logic       out_free;
    logic       proc;
    logic       emit;

    ffsc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign proc     = byte_valid_reg && out_free;
    assign in_stall = byte_valid_reg && !out_free;

    ffsc_parser #(.FRAME_COUNT(FRAME_COUNT)) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (proc && cfg.enable),
        .data_byte (byte_reg),
        .cfg       (cfg),
        .emit      (emit),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                byte_valid_reg <= in_valid;
            if (proc && emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            byte_reg <= data_byte;
        if (proc && emit)
            res_reg <= result;
    end

    assign out_valid           = out_valid_reg;
    assign status              = res_reg.status;
    assign trigger_value       = res_reg.trigger_value;
    assign run_mode            = res_reg.run_mode;
    assign last_payload_length = res_reg.last_payload_length;

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the front-end frame sequence checker.
// ----------------------------------------------------------------------------
// Feeds byte streams made of directed frames, well-formed events with random
// content, corrupted events and noise. Every accepted byte goes through a
// frame parser model that queues the report each event should end with, and
// each report taken from the block is checked against the oldest one queued.
// Register writes go over the APB port while the block is idle. Both sides
// stall at random, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_FRAMES    = ffsc_pkg::FRAME_COUNT_DEFAULT;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_SHOWN     = 10;

    localparam logic [ffsc_pkg::ADDR_W-1:0] ADDR_ENABLE      = (ffsc_pkg::ADDR_W)'(0);
    localparam logic [ffsc_pkg::ADDR_W-1:0] ADDR_UNCOMP_MODE = (ffsc_pkg::ADDR_W)'(4);

    localparam logic [7:0] SYNC_A = 8'hEB;
    localparam logic [7:0] SYNC_B = 8'h90;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_TRIG,
        PH_MODE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_TRAILER
    } phase_e;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_SYNC1,
        ST_BAD_SYNC2,
        ST_TRIG_MISMATCH,
        ST_MODE_MISMATCH
    } status_e;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ffsc_pkg::ADDR_W-1:0]   paddr;
    logic [ffsc_pkg::DATA_W-1:0]   pwdata;
    logic [ffsc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          in_valid;
    logic                          in_stall;
    logic [7:0]                    data_byte;
    logic                          out_valid;
    logic                          out_stall;
    logic [2:0]                    status;
    logic [7:0]                    trigger_value;
    logic [3:0]                    run_mode;
    logic signed [15:0]            last_payload_length;

    logic        cfg_enable      = 1'b0;
    logic [3:0]  cfg_uncomp_mode = 4'd0;
    phase_e      phase           = PH_SYNC1;
    logic [3:0]  frame_num       = 4'd0;
    logic [7:0]  trig_latch      = 8'd0;
    logic [3:0]  mode_latch      = 4'd0;
    logic [7:0]  len_hi          = 8'd0;
    logic [15:0] pay_left        = 16'd0;
    logic [1:0]  grp_pos         = 2'd0;
    logic [1:0]  trail_cnt       = 2'd0;
    logic [15:0] last_plen       = 16'd0;

    ffsc_pkg::result_t expected_reports[$];
    ffsc_pkg::result_t want_rpt;
    logic [7:0]        event_bytes[$];

    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          hold_left      = 0;
    logic        hold_req;
    int          cycle_count    = 0;
    int          bytes_sent     = 0;
    int          reports_checked = 0;
    int          mismatch_count = 0;
    int          status_seen[8];

    fee_frame_sequence_checker #(
        .FRAME_COUNT(NUM_FRAMES)
    ) u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .data_byte           (data_byte),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .status              (status),
        .trigger_value       (trigger_value),
        .run_mode            (run_mode),
        .last_payload_length (last_payload_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void close_event(input status_e code);
        ffsc_pkg::result_t rpt;
        rpt.status              = code;
        rpt.trigger_value       = trig_latch;
        rpt.run_mode            = mode_latch;
        rpt.last_payload_length = last_plen;
        expected_reports.push_back(rpt);
        phase     = PH_SYNC1;
        frame_num = 4'd0;
        grp_pos   = 2'd0;
        trail_cnt = 2'd0;
        pay_left  = 16'd0;
    endfunction

    function automatic void parse_byte(input logic [7:0] value);
        logic [15:0] plen;
        int unsigned grp;
        if (!cfg_enable)
            return;
        case (phase)
            PH_SYNC1:
                if (value != SYNC_A)
                    close_event(ST_BAD_SYNC1);
                else
                    phase = PH_SYNC2;
            PH_SYNC2:
                if (value != SYNC_B)
                    close_event(ST_BAD_SYNC2);
                else
                    phase = PH_TRIG;
            PH_TRIG:
                if (frame_num == 4'd0)
                begin
                    trig_latch = value;
                    phase = PH_MODE;
                end
                else if (trig_latch != value)
                    close_event(ST_TRIG_MISMATCH);
                else
                    phase = PH_MODE;
            PH_MODE:
                if (frame_num == 4'd0)
                begin
                    mode_latch = value[7:4];
                    phase = PH_LEN_HI;
                end
                else if (mode_latch != value[7:4])
                    close_event(ST_MODE_MISMATCH);
                else
                    phase = PH_LEN_HI;
            PH_LEN_HI:
            begin
                len_hi = value;
                phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                plen = {len_hi, value} - 16'd6;
                last_plen = plen;
                grp_pos = 2'd0;
                trail_cnt = 2'd0;
                if (plen == 16'd0 || plen[15])
                begin
                    pay_left = 16'd0;
                    phase = PH_TRAILER;
                end
                else
                begin
                    pay_left = plen;
                    phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                grp = (mode_latch == cfg_uncomp_mode) ? 2 : 3;
                grp_pos = grp_pos + 2'd1;
                if (grp_pos >= grp)
                begin
                    grp_pos = 2'd0;
                    pay_left = (pay_left > grp) ? pay_left - 16'(grp) : 16'd0;
                    if (pay_left == 16'd0)
                    begin
                        trail_cnt = 2'd0;
                        phase = PH_TRAILER;
                    end
                end
            end
            default:
                if (trail_cnt < 2'd3)
                    trail_cnt = trail_cnt + 2'd1;
                else
                begin
                    trail_cnt = 2'd0;
                    if (int'(frame_num) + 1 >= NUM_FRAMES)
                        close_event(ST_OK);
                    else
                    begin
                        frame_num = frame_num + 4'd1;
                        phase = PH_SYNC1;
                    end
                end
        endcase
    endfunction

    function automatic logic [15:0] pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65)
            return 16'd6 + 16'($urandom_range(0, 20));
        else if (r < 75)
            return 16'($urandom_range(0, 5));
        else if (r < 85)
            return {8'($urandom_range(8'h81, 8'hFF)), 8'($urandom)};
        else if (r < 98)
            return 16'd6 + 16'($urandom_range(21, 60));
        else
            return 16'd6 + 16'($urandom_range(250, 300));
    endfunction

    function automatic void add_frame(input logic [7:0] trig, input logic [7:0] mode_byte,
                                      input logic [15:0] len_field);
        logic [15:0] plen;
        int unsigned grp;
        int unsigned span;
        plen = len_field - 16'd6;
        grp  = (mode_byte[7:4] == cfg_uncomp_mode) ? 2 : 3;
        span = (plen == 16'd0 || plen[15]) ? 0 : ((int'(plen) + grp - 1) / grp) * grp;
        event_bytes.push_back(SYNC_A);
        event_bytes.push_back(SYNC_B);
        event_bytes.push_back(trig);
        event_bytes.push_back(mode_byte);
        event_bytes.push_back(len_field[15:8]);
        event_bytes.push_back(len_field[7:0]);
        repeat (span + 4) event_bytes.push_back(8'($urandom));
    endfunction

    function automatic void add_event(input logic [7:0] trig, input logic [3:0] mode_nib,
                                      input bit corrupt);
        int unsigned bad_frame;
        int unsigned bad_pos;
        bad_frame = $urandom_range(0, NUM_FRAMES - 1);
        bad_pos = 0;
        for (int f = 0; f < NUM_FRAMES; f++)
        begin
            if (corrupt && f == bad_frame)
                bad_pos = event_bytes.size() + $urandom_range(0, 3);
            add_frame(trig, {mode_nib, 4'($urandom)}, pick_length());
        end
        if (corrupt)
            event_bytes[bad_pos] = 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] value);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
        parse_byte(value);
    endtask

    task automatic send_queued();
        while (event_bytes.size() != 0)
            send_byte(event_bytes.pop_front());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ffsc_pkg::ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ENABLE)
            cfg_enable = value[0];
        else if (addr == ADDR_UNCOMP_MODE)
            cfg_uncomp_mode = value[3:0];
        @(posedge clk);
    endtask

    // finish the frame in flight, then the rest of the event
    task automatic finish_event();
        while (phase == PH_PAYLOAD || phase == PH_TRAILER)
            send_byte(8'($urandom));
        if (frame_num != 4'd0)
            for (int f = frame_num; f < NUM_FRAMES; f++)
                add_frame(trig_latch, {mode_latch, 4'($urandom)}, pick_length());
        send_queued();
    endtask

    task automatic test_disabled();
        write_reg(ADDR_ENABLE, 32'd0);
        write_reg(ADDR_UNCOMP_MODE, 32'd0);
        event_bytes = '{SYNC_A, SYNC_B, 8'h11, 8'h22, 8'h00, 8'h06, 8'h00, 8'hFF};
        send_queued();
        drain();
    endtask

    task automatic test_directed_frames();
        write_reg(ADDR_ENABLE, 32'd1);
        event_bytes = '{8'h00, 8'hFF, SYNC_A, 8'h91};
        add_frame(8'hFF, 8'h0F, 16'd11);
        add_frame(8'hFF, 8'h0A, 16'd6);
        add_frame(8'hFF, 8'h05, 16'h0000);
        add_frame(8'hFF, 8'h00, 16'hFFFF);
        add_frame(8'h00, 8'hF3, 16'd10);
        event_bytes.push_back(SYNC_A);
        event_bytes.push_back(SYNC_B);
        event_bytes.push_back(8'h01);
        add_frame(8'h5A, 8'h70, 16'd6);
        add_frame(8'h5A, 8'h7C, 16'd6);
        event_bytes.push_back(SYNC_A);
        event_bytes.push_back(SYNC_B);
        event_bytes.push_back(8'h5A);
        event_bytes.push_back(8'h80);
        send_queued();
        drain();
    endtask

    task automatic test_mode_switch_mid_frame();
        write_reg(ADDR_UNCOMP_MODE, 32'd0);
        event_bytes = '{SYNC_A, SYNC_B, 8'h3C, 8'h0A, 8'h00, 8'h10, 8'h21, 8'h22, 8'h23};
        send_queued();
        drain();
        write_reg(ADDR_UNCOMP_MODE, 32'd15);
        finish_event();
        drain();
    endtask

    task automatic test_enable_toggle();
        write_reg(ADDR_UNCOMP_MODE, 32'd9);
        event_bytes = '{SYNC_A, SYNC_B, 8'hC3, 8'h96, 8'h00, 8'h0E, 8'h41, 8'h42};
        send_queued();
        drain();
        write_reg(ADDR_ENABLE, 32'd0);
        repeat (6) send_byte(8'($urandom));
        drain();
        write_reg(ADDR_ENABLE, 32'd1);
        finish_event();
        drain();
    endtask

    task automatic test_output_backpressure();
        hold_req <= 1'b1;
        repeat (24) event_bytes.push_back(8'($urandom_range(0, 8'hEA)));
        add_event(8'($urandom), 4'($urandom), 1'b0);
        send_queued();
        drain();
    endtask

    task automatic test_random_stream(input int send_pct, input int recv_pct,
                                      input logic [3:0] code, input int target);
        int first;
        int unsigned r;
        write_reg(ADDR_UNCOMP_MODE, {28'd0, code});
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first = bytes_sent;
        while (bytes_sent - first < target)
        begin
            r = $urandom_range(99);
            if (r < 93)
                add_event(8'($urandom), $urandom_range(1) ? code : 4'($urandom), r >= 78);
            else
                repeat ($urandom_range(1, 4)) event_bytes.push_back(8'($urandom));
            send_queued();
        end
        drain();
    endtask

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_req <= 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            reports_checked++;
            status_seen[status]++;
            if (expected_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("unexpected report: status %0d trigger %02h mode %0h length %0d",
                             status, trigger_value, run_mode, last_payload_length);
            end
            else
            begin
                want_rpt = expected_reports.pop_front();
                if (status !== want_rpt.status || trigger_value !== want_rpt.trigger_value ||
                    run_mode !== want_rpt.run_mode ||
                    last_payload_length !== want_rpt.last_payload_length)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display({"report %0d: expected status %0d trigger %02h mode %0h ",
                                  "length %0d, got status %0d trigger %02h mode %0h length %0d"},
                                 reports_checked, want_rpt.status, want_rpt.trigger_value,
                                 want_rpt.run_mode, want_rpt.last_payload_length, status,
                                 trigger_value, run_mode, last_payload_length);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, expected_reports.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        data_byte = 8'd0;
        out_stall = 1'b0;
        hold_req  = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 28;
        recv_idle_pct = 83;
        test_disabled();
        test_directed_frames();
        test_mode_switch_mid_frame();
        test_enable_toggle();
        test_output_backpressure();
        test_random_stream(28, 83, 4'hF, 250);
        test_random_stream(83, 28, 4'($urandom_range(1, 14)), 250);
        test_random_stream(0, 0, 4'h0, 300);

        $display("covered %0d bytes and %0d reports: %0d complete events, %0d sync errors,",
                 bytes_sent, reports_checked, status_seen[ST_OK],
                 status_seen[ST_BAD_SYNC1] + status_seen[ST_BAD_SYNC2]);
        $display("%0d trigger and %0d mode mismatches, both group sizes, enable toggling",
                 status_seen[ST_TRIG_MISMATCH], status_seen[ST_MODE_MISMATCH]);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
